// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/iso_ts_pkg.sv
package iso_ts_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned FIELD_W  = 7;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned DAYS_W   = 22;
  localparam int unsigned TOD_W    = 17;
  localparam int unsigned EPOCH_W  = 38;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [YEAR_W-1:0]  MIN_YEAR     = 14'd1970;
  localparam logic [FIELD_W-1:0] MAX_MONTH    = 7'd12;
  localparam logic [FIELD_W-1:0] MAX_DAY      = 7'd31;
  localparam logic [FIELD_W-1:0] MAX_HOUR     = 7'd23;
  localparam logic [FIELD_W-1:0] MAX_MIN_SEC  = 7'd59;
  localparam logic [3:0]         MAX_FRAC     = 4'd9;
  localparam logic [POS_W-1:0]   POS_MAX      = 16'hFFFF;

  // 719468 days from 0000-03-01 to the epoch, plus one for the 1-based day.
  localparam logic [22:0]        DAY_OFFSET   = 23'd719469;
  // ceil(2^16 / 25), exact for quotients of values below 4681.
  localparam logic [11:0]        RECIP_25     = 12'd2622;
  localparam logic [16:0]        SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0]        SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]         SEC_PER_MIN  = 6'd60;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_Z     = 8'h5A;

  typedef enum logic [3:0] {
    PH_YEAR, PH_SEP1, PH_MONTH, PH_SEP2, PH_DAY, PH_TSEP, PH_HOUR, PH_SEP3,
    PH_MINUTE, PH_SEP4, PH_SECOND, PH_DOT, PH_FRAC, PH_ZED, PH_DONE, PH_ERR
  } scan_phase_t;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_DIGIT, ERR_YEAR, ERR_MONTH, ERR_DAY, ERR_SEPARATOR,
    ERR_HOUR, ERR_MINUTE, ERR_SECOND, ERR_TRAILING
  } err_code_t;

  typedef enum logic [2:0] {
    ST_SCAN, ST_ADJ, ST_MUL, ST_SUM, ST_SECMUL, ST_LOAD
  } ctrl_state_t;

  typedef enum logic [2:0] {
    CMD_IDLE, CMD_ADJ, CMD_MUL, CMD_SUM, CMD_SECMUL, CMD_LOAD
  } calc_cmd_t;

  typedef struct packed {
    calc_cmd_t cmd;
    logic      clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    err_code_t          err;
    logic [POS_W-1:0]   err_pos;
  } scan_fields_t;

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] doy;
    unique case (month)
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

// File: rtl/iso_ts_ctrl.sv
`include "assert_macros.svh"

module iso_ts_ctrl
  import iso_ts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tlast,
  input  logic      out_free,
  output logic      s_tready,
  output ctrl_cmd_t ctrl
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctrl.cmd   = CMD_IDLE;
    ctrl.clear = 1'b0;
    unique case (state)
      ST_SCAN: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) begin
          state_next = ST_ADJ;
        end
      end
      ST_ADJ: begin
        ctrl.cmd   = CMD_ADJ;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctrl.cmd   = CMD_MUL;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        ctrl.cmd   = CMD_SUM;
        state_next = ST_SECMUL;
      end
      ST_SECMUL: begin
        ctrl.cmd   = CMD_SECMUL;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // Wait here until the previous result has left the output register.
        if (out_free) begin
          ctrl.cmd   = CMD_LOAD;
          ctrl.clear = 1'b1;
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_SCAN;
    endcase
  end

  `ASSERT_NEXT(a_last_starts_conv, clk, rst, state == ST_SCAN && s_tvalid && s_tlast, state == ST_ADJ)
  `ASSERT_IMPLIES(a_clear_with_load, clk, rst, ctrl.clear, ctrl.cmd == CMD_LOAD)
  `ASSERT_NEXT(a_load_returns, clk, rst, ctrl.cmd == CMD_LOAD, state == ST_SCAN)

endmodule

// File: rtl/iso_ts_scanner.sv
`include "assert_macros.svh"

module iso_ts_scanner
  import iso_ts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   character,
  input  logic         last_character,
  input  logic         clear,
  output scan_fields_t fields
);

  scan_phase_t        phase;
  logic [3:0]         digit_count;
  logic [YEAR_W-1:0]  year_value;
  logic [FIELD_W-1:0] month_value;
  logic [FIELD_W-1:0] day_value;
  logic [FIELD_W-1:0] hour_value;
  logic [FIELD_W-1:0] minute_value;
  logic [FIELD_W-1:0] second_value;
  logic [POS_W-1:0]   char_position;
  err_code_t          latched_error;
  logic [POS_W-1:0]   latched_error_position;

  scan_phase_t        phase_next;
  logic [3:0]         digit_count_next;
  logic [YEAR_W-1:0]  year_value_next;
  logic [FIELD_W-1:0] month_value_next;
  logic [FIELD_W-1:0] day_value_next;
  logic [FIELD_W-1:0] hour_value_next;
  logic [FIELD_W-1:0] minute_value_next;
  logic [FIELD_W-1:0] second_value_next;
  logic [POS_W-1:0]   char_position_next;
  err_code_t          latched_error_next;
  logic [POS_W-1:0]   latched_error_position_next;

  scan_phase_t        ph;
  logic               used;
  logic               is_digit;
  logic [3:0]         digit;
  logic [7:0]         sep_char;
  logic [YEAR_W-1:0]  cur;
  logic [YEAR_W-1:0]  acc;
  logic [3:0]         need;
  logic [POS_W-1:0]   end_pos;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase                  <= PH_YEAR;
      digit_count            <= '0;
      year_value             <= '0;
      month_value            <= '0;
      day_value              <= '0;
      hour_value             <= '0;
      minute_value           <= '0;
      second_value           <= '0;
      char_position          <= '0;
      latched_error          <= ERR_NONE;
      latched_error_position <= '0;
    end else begin
      phase                  <= phase_next;
      digit_count            <= digit_count_next;
      year_value             <= year_value_next;
      month_value            <= month_value_next;
      day_value              <= day_value_next;
      hour_value             <= hour_value_next;
      minute_value           <= minute_value_next;
      second_value           <= second_value_next;
      char_position          <= char_position_next;
      latched_error          <= latched_error_next;
      latched_error_position <= latched_error_position_next;
    end
  end

  assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign digit    = 4'(character - CHAR_ZERO);
  assign end_pos  = (char_position == POS_MAX) ? POS_MAX : char_position + 16'd1;

  always_comb begin
    ph                          = phase;
    used                        = 1'b0;
    sep_char                    = CHAR_COLON;
    cur                         = '0;
    acc                         = '0;
    need                        = 4'd2;
    digit_count_next            = digit_count;
    year_value_next             = year_value;
    month_value_next            = month_value;
    day_value_next              = day_value;
    hour_value_next             = hour_value;
    minute_value_next           = minute_value;
    second_value_next           = second_value;
    char_position_next          = char_position;
    latched_error_next          = latched_error;
    latched_error_position_next = latched_error_position;

    if (take) begin
      // An optional separator either eats the character or is skipped, and
      // the same character then goes on to the digit field after it.
      if (ph inside {PH_SEP1, PH_SEP2, PH_SEP3, PH_SEP4}) begin
        sep_char = (ph == PH_SEP1 || ph == PH_SEP2) ? CHAR_DASH : CHAR_COLON;
        used     = (character == sep_char);
        ph       = scan_phase_t'(4'(ph) + 4'd1);
      end

      if (!used) begin
        unique case (ph) inside
          PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
            if (!is_digit) begin
              latched_error_next          = ERR_DIGIT;
              latched_error_position_next = char_position;
              ph                          = PH_ERR;
            end else begin
              used = 1'b1;
              unique case (ph) inside
                PH_YEAR:   cur = year_value;
                PH_MONTH:  cur = YEAR_W'(month_value);
                PH_DAY:    cur = YEAR_W'(day_value);
                PH_HOUR:   cur = YEAR_W'(hour_value);
                PH_MINUTE: cur = YEAR_W'(minute_value);
                default:   cur = YEAR_W'(second_value);
              endcase
              acc  = (cur << 3) + (cur << 1) + YEAR_W'(digit);
              need = (ph == PH_YEAR) ? 4'd4 : 4'd2;
              unique case (ph) inside
                PH_YEAR:   year_value_next   = acc;
                PH_MONTH:  month_value_next  = acc[FIELD_W-1:0];
                PH_DAY:    day_value_next    = acc[FIELD_W-1:0];
                PH_HOUR:   hour_value_next   = acc[FIELD_W-1:0];
                PH_MINUTE: minute_value_next = acc[FIELD_W-1:0];
                default:   second_value_next = acc[FIELD_W-1:0];
              endcase
              digit_count_next = digit_count + 4'd1;
              if (digit_count_next == need) begin
                digit_count_next            = '0;
                latched_error_position_next = end_pos;
                unique case (ph) inside
                  PH_YEAR: begin
                    if (acc < MIN_YEAR) latched_error_next = ERR_YEAR;
                    ph = PH_SEP1;
                  end
                  PH_MONTH: begin
                    if (acc[FIELD_W-1:0] == '0 || acc[FIELD_W-1:0] > MAX_MONTH) begin
                      latched_error_next = ERR_MONTH;
                    end
                    ph = PH_SEP2;
                  end
                  PH_DAY: begin
                    if (acc[FIELD_W-1:0] == '0 || acc[FIELD_W-1:0] > MAX_DAY) begin
                      latched_error_next = ERR_DAY;
                    end
                    ph = PH_TSEP;
                  end
                  PH_HOUR: begin
                    if (acc[FIELD_W-1:0] > MAX_HOUR) latched_error_next = ERR_HOUR;
                    ph = PH_SEP3;
                  end
                  PH_MINUTE: begin
                    if (acc[FIELD_W-1:0] > MAX_MIN_SEC) latched_error_next = ERR_MINUTE;
                    ph = PH_SEP4;
                  end
                  default: begin
                    if (acc[FIELD_W-1:0] > MAX_MIN_SEC) latched_error_next = ERR_SECOND;
                    ph = PH_DOT;
                  end
                endcase
                if (latched_error_next != ERR_NONE) begin
                  ph = PH_ERR;
                end else begin
                  latched_error_position_next = latched_error_position;
                end
              end
            end
          end
          PH_TSEP: begin
            if (character == CHAR_T || character == CHAR_SPACE) begin
              used = 1'b1;
              ph   = PH_HOUR;
            end else begin
              latched_error_next          = ERR_SEPARATOR;
              latched_error_position_next = char_position;
              ph                          = PH_ERR;
            end
          end
          PH_DOT: begin
            if (character == CHAR_DOT) begin
              used             = 1'b1;
              ph               = PH_FRAC;
              digit_count_next = '0;
            end else begin
              ph = PH_ZED;
            end
          end
          PH_FRAC: begin
            if (is_digit && digit_count < MAX_FRAC) begin
              used             = 1'b1;
              digit_count_next = digit_count + 4'd1;
            end else begin
              ph               = PH_ZED;
              digit_count_next = '0;
            end
          end
          default: ;
        endcase
      end

      if (!used && ph == PH_ZED) begin
        used = (character == CHAR_Z);
        ph   = PH_DONE;
      end

      if (!used && ph == PH_DONE) begin
        latched_error_next          = ERR_TRAILING;
        latched_error_position_next = char_position;
        ph                          = PH_ERR;
      end

      if (used) begin
        char_position_next = end_pos;
      end

      // A string that ends where more is required reports at its length.
      if (last_character && ph != PH_ERR &&
          !(ph inside {PH_DOT, PH_FRAC, PH_ZED, PH_DONE})) begin
        latched_error_next          = (ph == PH_TSEP) ? ERR_SEPARATOR : ERR_DIGIT;
        latched_error_position_next = char_position_next;
        ph                          = PH_ERR;
      end
    end

    phase_next = ph;
  end

  assign fields.year    = year_value;
  assign fields.month   = month_value;
  assign fields.day     = day_value;
  assign fields.hour    = hour_value;
  assign fields.minute  = minute_value;
  assign fields.second  = second_value;
  assign fields.err     = latched_error;
  assign fields.err_pos = latched_error_position;

  `ASSERT_IMPLIES(a_err_only_in_err_phase, clk, rst, phase != PH_ERR, latched_error == ERR_NONE)
  `ASSERT_IMPLIES(a_err_phase_has_code, clk, rst, phase == PH_ERR, latched_error != ERR_NONE)
  `ASSERT_NEXT(a_error_sticks, clk, rst, phase == PH_ERR && !clear, phase == PH_ERR && $stable(latched_error))

endmodule

// File: rtl/iso_ts_calc.sv
`include "assert_macros.svh"

module iso_ts_calc
  import iso_ts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  calc_cmd_t              cmd,
  input  scan_fields_t           fields,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   out_free
);

  logic [YEAR_W-1:0]  adj_year;
  logic [23:0]        q25_prod;
  logic [16:0]        hour_secs;
  logic [11:0]        min_secs;
  logic [6:0]         q100;
  logic [DAYS_W-1:0]  days365;
  logic [TOD_W-1:0]   tod;
  logic [DAYS_W-1:0]  days;
  logic [EPOCH_W-1:0] day_secs;

  logic [EPOCH_W-1:0] epoch_seconds;
  err_code_t          error_code;
  logic [POS_W-1:0]   error_position;

  logic [YEAR_W-1:0]  adj_year_next;
  logic [22:0]        days_sum;
  logic [38:0]        day_secs_full;

  // A year begins in March here, so January and February count with the
  // year before.
  assign adj_year_next = (fields.month <= 7'd2) ? fields.year - 14'd1 : fields.year;

  assign days_sum = 23'(days365) + 23'(adj_year[YEAR_W-1:2]) + 23'(q100[6:2])
                  + 23'(month_start(fields.month[3:0])) + 23'(fields.day)
                  - 23'(q100) - DAY_OFFSET;

  assign day_secs_full = days * SEC_PER_DAY;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_ADJ: begin
        adj_year  <= adj_year_next;
        q25_prod  <= adj_year_next[YEAR_W-1:2] * RECIP_25;
        hour_secs <= fields.hour * SEC_PER_HOUR;
        min_secs  <= fields.minute[5:0] * SEC_PER_MIN;
      end
      CMD_MUL: begin
        q100    <= q25_prod[22:16];
        days365 <= adj_year * 9'd365;
        tod     <= hour_secs + TOD_W'(min_secs) + TOD_W'(fields.second);
      end
      CMD_SUM: begin
        days <= days_sum[DAYS_W-1:0];
      end
      CMD_SECMUL: begin
        day_secs <= day_secs_full[EPOCH_W-1:0];
      end
      CMD_LOAD: begin
        if (fields.err != ERR_NONE) begin
          epoch_seconds  <= '0;
          error_code     <= fields.err;
          error_position <= fields.err_pos;
        end else begin
          epoch_seconds  <= day_secs + EPOCH_W'(tod);
          error_code     <= ERR_NONE;
          error_position <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd == CMD_LOAD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {6'd0, error_position, error_code, epoch_seconds};

  `ASSERT_IMPLIES(a_load_needs_room, clk, rst, cmd == CMD_LOAD, out_free)
  `ASSERT_IMPLIES(a_error_zero_epoch, clk, rst, m_tvalid && error_code != ERR_NONE, epoch_seconds == '0)
  `ASSERT_IMPLIES(a_ok_zero_pos, clk, rst, m_tvalid && error_code == ERR_NONE, error_position == '0)

endmodule

// File: rtl/iso8601_timestamp_parser.sv
// Parses an ISO-8601 UTC timestamp (YYYY[-]MM[-]DD{T| }hh[:]mm[:]ss[.f..][Z]), one ASCII
// character per item with tlast on the final one, and returns one result per string: the
// Unix seconds, or an error code with the character position where parsing stopped.
// Characters are taken one per clock cycle. After the character marked last the input
// stalls while the calendar conversion runs through its steps (year adjust, the year
// multiply, the day sum, the seconds multiply and the final add); the result then sits
// in an output register, and the final add waits only while that register still holds
// a result that has not been taken.
module iso8601_timestamp_parser
  import iso_ts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,  // character
  input  logic                   s_tlast,  // last_character
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // epoch_seconds, error_code, error_position, zeros
);

  ctrl_cmd_t    ctrl;
  scan_fields_t fields;
  logic         out_free;
  logic         take;

  assign take = s_tvalid && s_tready;

  iso_ts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .out_free (out_free),
    .s_tready (s_tready),
    .ctrl     (ctrl)
  );

  iso_ts_scanner u_scanner (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .character      (s_tdata),
    .last_character (s_tlast),
    .clear          (ctrl.clear),
    .fields         (fields)
  );

  iso_ts_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ctrl.cmd),
    .fields   (fields),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .out_free (out_free)
  );

endmodule
